// ===== rtl/hidev_pkg.sv =====
package hidev_pkg;

	localparam int NumButtons = 5;
	localparam logic [4:0] ButtonMask = 5'((1 << NumButtons) - 1);
	localparam int NumSlots = 9;
	localparam int SecBits = 34;
	localparam int UsecBits = 20;
	// one second is 512 * 1953125 ns
	localparam logic [20:0] SecDiv = 21'd1953125;
	// ceil(2^75 / 1953125), exact quotient for any 54-bit dividend
	localparam logic [54:0] SecRecip = 55'd19342813113834067;
	localparam logic [26:0] SecRecipHi = SecRecip[54:28];
	localparam logic [27:0] SecRecipLo = SecRecip[27:0];
	// ceil(2^34 / 125), exact quotient for any 27-bit dividend
	localparam logic [27:0] UsecRecip = 28'd137438954;
	localparam int FifoDepth = 4;

	typedef enum logic [1:0] {
		KindKbd = 2'd0,
		KindRel = 2'd1,
		KindAbs = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		EvSyn = 2'd0,
		EvKey = 2'd1,
		EvRel = 2'd2,
		EvAbs = 2'd3
	} ev_type_t;

	localparam logic [9:0] AxisX = 10'd0;
	localparam logic [9:0] AxisY = 10'd1;
	localparam logic [9:0] RelWheel = 10'd8;
	localparam logic [9:0] SynCode = 10'd0;

	localparam logic [9:0] ButtonCodes [5] = '{10'd272, 10'd274, 10'd273, 10'd275, 10'd276};

	localparam logic [7:0] LetterKeys [26] = '{
		8'd30, 8'd48, 8'd46, 8'd32, 8'd18, 8'd33, 8'd34, 8'd35, 8'd23, 8'd36, 8'd37, 8'd38,
		8'd50, 8'd49, 8'd24, 8'd25, 8'd16, 8'd19, 8'd31, 8'd20, 8'd22, 8'd47, 8'd17, 8'd45,
		8'd21, 8'd44};
	localparam logic [7:0] PunctKeys [18] = '{
		8'd28, 8'd1, 8'd14, 8'd15, 8'd57, 8'd12, 8'd13, 8'd26, 8'd27, 8'd43, 8'd86, 8'd39,
		8'd40, 8'd41, 8'd51, 8'd52, 8'd53, 8'd58};
	localparam logic [7:0] NavKeys [16] = '{
		8'd87, 8'd88, 8'd99, 8'd70, 8'd119, 8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109,
		8'd106, 8'd105, 8'd108, 8'd103, 8'd69};
	localparam logic [7:0] ModKeys [8] = '{
		8'd29, 8'd42, 8'd56, 8'd125, 8'd97, 8'd54, 8'd100, 8'd126};

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] scancode;
		logic key_released;
		logic signed [31:0] move_x;
		logic signed [31:0] move_y;
		logic signed [31:0] move_z;
		logic [14:0] pos_x;
		logic [14:0] pos_y;
		logic signed [31:0] tablet_wheel;
		logic [4:0] button_mask;
		logic [62:0] time_ns;
	} hidev_in_t;

	typedef struct packed {
		logic [33:0] stamp_sec;
		logic [19:0] stamp_usec;
		logic [1:0] event_type;
		logic [9:0] event_code;
		logic signed [31:0] event_value;
		logic last;
	} hidev_out_t;

	typedef struct packed {
		logic [NumSlots-1:0] mask;
		kind_t kind;
		logic [9:0] code0;
		logic [31:0] val0;
		logic [31:0] val1;
		logic [31:0] wheel;
		logic [4:0] btn;
	} hidev_rec_t;

	typedef struct packed {
		hidev_rec_t rec;
		logic [SecBits-1:0] sec;
		logic [UsecBits-1:0] usec;
	} hidev_job_t;

	function automatic logic [9:0] usage_to_key(input logic [7:0] u);
		logic [7:0] k;
		k = 8'd0;
		if (u >= 8'd4 && u <= 8'd29) begin
			k = LetterKeys[5'(u - 8'd4)];
		end else if (u >= 8'd30 && u <= 8'd38) begin
			k = u - 8'd28;
		end else if (u == 8'd39) begin
			k = 8'd11;
		end else if (u >= 8'd40 && u <= 8'd57) begin
			k = PunctKeys[5'(u - 8'd40)];
		end else if (u >= 8'd58 && u <= 8'd67) begin
			k = u + 8'd1;
		end else if (u >= 8'd68 && u <= 8'd83) begin
			k = NavKeys[4'(u - 8'd68)];
		end else if (u >= 8'd224 && u <= 8'd231) begin
			k = ModKeys[3'(u - 8'd224)];
		end
		return {2'b00, k};
	endfunction

endpackage

// ===== rtl/hidev_front.sv =====
module hidev_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_data,
	input  logic                  accept,
	input  hidev_pkg::hidev_in_t  in_item,
	output hidev_pkg::hidev_rec_t rec,
	output logic                  has_ev
);

	logic [1:0]  kind_q;
	logic [4:0]  held_q;
	logic [14:0] last_x_q;
	logic [14:0] last_y_q;
	logic        seen_q;

	logic        kbd;
	logic        rel;
	logic        abs_m;
	logic [9:0]  key;
	logic [4:0]  chg;
	logic [hidev_pkg::NumSlots-1:0] mask;

	always_comb begin
		kbd   = (kind_q == hidev_pkg::KindKbd) && (in_item.func == hidev_pkg::KindKbd);
		rel   = (kind_q == hidev_pkg::KindRel) && (in_item.func == hidev_pkg::KindRel);
		abs_m = (kind_q == hidev_pkg::KindAbs) && (in_item.func == hidev_pkg::KindAbs);
		key   = hidev_pkg::usage_to_key(in_item.scancode);
		chg   = (in_item.button_mask ^ held_q) & hidev_pkg::ButtonMask;
		mask[0] = (kbd && key != 10'd0) || (rel && in_item.move_x != 32'sd0)
			|| (abs_m && (!seen_q || in_item.pos_x != last_x_q));
		mask[1] = (rel && in_item.move_y != 32'sd0)
			|| (abs_m && (!seen_q || in_item.pos_y != last_y_q));
		mask[2] = rel && in_item.move_z != 32'sd0;
		mask[7:3] = (rel || abs_m) ? chg : 5'd0;
		mask[8] = abs_m && in_item.tablet_wheel != 32'sd0;

		rec.mask  = mask;
		rec.kind  = hidev_pkg::kind_t'(kind_q);
		rec.code0 = kbd ? key : hidev_pkg::AxisX;
		if (kbd) begin
			rec.val0 = {31'd0, ~in_item.key_released};
		end else if (rel) begin
			rec.val0 = in_item.move_x;
		end else begin
			rec.val0 = {17'd0, in_item.pos_x};
		end
		rec.val1  = rel ? (32'd0 - in_item.move_y) : {17'd0, in_item.pos_y};
		rec.wheel = rel ? in_item.move_z : in_item.tablet_wheel;
		rec.btn   = in_item.button_mask & hidev_pkg::ButtonMask;
		has_ev    = mask != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= hidev_pkg::KindKbd;
			held_q   <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
			seen_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				kind_q <= cfg_data;
			end
			if (accept && (rel || abs_m)) begin
				held_q <= in_item.button_mask & hidev_pkg::ButtonMask;
			end
			if (accept && abs_m) begin
				last_x_q <= in_item.pos_x;
				last_y_q <= in_item.pos_y;
				seen_q   <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/hidev_stamp.sv =====
module hidev_stamp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_vld,
	input  hidev_pkg::hidev_rec_t in_rec,
	input  logic [62:0]           time_ns,
	output logic                  out_vld,
	output hidev_pkg::hidev_job_t out_job
);

	logic                            vld_s1;
	logic                            vld_s2;
	logic                            vld_s3;
	logic                            vld_s4;
	hidev_pkg::hidev_rec_t           rec_s1;
	hidev_pkg::hidev_rec_t           rec_s2;
	hidev_pkg::hidev_rec_t           rec_s3;
	hidev_pkg::hidev_rec_t           rec_s4;
	logic [26:0]                     tl_s1;
	logic [26:0]                     tl_s2;
	logic [53:0]                     phh_s1;
	logic [54:0]                     phl_s1;
	logic [53:0]                     plh_s1;
	logic [54:0]                     pll_s1;
	logic [hidev_pkg::SecBits-1:0]   sec_s2;
	logic [hidev_pkg::SecBits-1:0]   sec_s3;
	logic [hidev_pkg::SecBits-1:0]   sec_s4;
	logic [26:0]                     ux_s3;
	logic [hidev_pkg::UsecBits-1:0]  usec_s4;

	logic [26:0]  t_hi;
	logic [26:0]  t_lo;
	logic [108:0] prod;
	logic [20:0]  rem;
	logic [54:0]  uprod;

	// seconds: (ns >> 9) / 1953125 by reciprocal, usec: ((rem << 6) + ns[8:3]) / 125
	always_comb begin
		t_hi  = time_ns[62:36];
		t_lo  = time_ns[35:9];
		prod  = {phh_s1, 55'd0} + {27'd0, phl_s1, 27'd0} + {27'd0, plh_s1, 28'd0}
			+ {54'd0, pll_s1};
		rem   = tl_s2[26:6] - 21'(sec_s2[20:0] * hidev_pkg::SecDiv);
		uprod = 55'(ux_s3) * 55'(hidev_pkg::UsecRecip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s1  <= in_rec;
			tl_s1   <= time_ns[29:3];
			phh_s1  <= 54'(t_hi) * 54'(hidev_pkg::SecRecipHi);
			phl_s1  <= 55'(t_hi) * 55'(hidev_pkg::SecRecipLo);
			plh_s1  <= 54'(t_lo) * 54'(hidev_pkg::SecRecipHi);
			pll_s1  <= 55'(t_lo) * 55'(hidev_pkg::SecRecipLo);
			rec_s2  <= rec_s1;
			tl_s2   <= tl_s1;
			sec_s2  <= prod[108:75];
			rec_s3  <= rec_s2;
			sec_s3  <= sec_s2;
			ux_s3   <= {rem, tl_s2[5:0]};
			rec_s4  <= rec_s3;
			sec_s4  <= sec_s3;
			usec_s4 <= uprod[53:34];
		end
	end

	assign out_vld      = vld_s4;
	assign out_job.rec  = rec_s4;
	assign out_job.sec  = sec_s4;
	assign out_job.usec = usec_s4;

endmodule

// ===== rtl/hidev_fifo.sv =====
module hidev_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  hidev_pkg::hidev_job_t wr_data,
	output logic                  fifo_full,
	input  logic                  rd,
	output hidev_pkg::hidev_job_t rd_data,
	output logic                  fifo_empty
);

	localparam int PtrBits = $clog2(hidev_pkg::FifoDepth);

	hidev_pkg::hidev_job_t mem_q [hidev_pkg::FifoDepth];
	logic [PtrBits-1:0] wp_q;
	logic [PtrBits-1:0] rp_q;
	logic [PtrBits:0]   cnt_q;

	assign fifo_full  = cnt_q == (PtrBits+1)'(hidev_pkg::FifoDepth);
	assign fifo_empty = cnt_q == '0;
	assign rd_data    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/hidev_back.sv =====
module hidev_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_empty,
	input  hidev_pkg::hidev_job_t job,
	output logic                  job_pop,
	output logic                  empty,
	input  logic                  pop,
	output hidev_pkg::hidev_out_t out_item
);

	hidev_pkg::hidev_job_t cur_q;
	logic [hidev_pkg::NumSlots:0] pend_q;
	logic                         out_vld_q;
	hidev_pkg::hidev_out_t        out_q;

	logic                         out_adv;
	logic                         busy;
	logic [hidev_pkg::NumSlots:0] sel;
	logic [hidev_pkg::NumSlots:0] pend_nxt;
	hidev_pkg::hidev_out_t        ev;

	always_comb begin
		out_adv  = !out_vld_q || pop;
		busy     = pend_q != '0;
		sel      = pend_q & (~pend_q + 1'b1);
		pend_nxt = (out_adv && busy) ? (pend_q & ~sel) : pend_q;
		job_pop  = (pend_nxt == '0) && !job_empty;

		ev.stamp_sec   = cur_q.sec;
		ev.stamp_usec  = cur_q.usec;
		ev.event_type  = hidev_pkg::EvSyn;
		ev.event_code  = hidev_pkg::SynCode;
		ev.event_value = '0;
		ev.last        = 1'b0;
		if (sel[0]) begin
			case (cur_q.rec.kind)
				hidev_pkg::KindKbd: ev.event_type = hidev_pkg::EvKey;
				hidev_pkg::KindRel: ev.event_type = hidev_pkg::EvRel;
				default: ev.event_type = hidev_pkg::EvAbs;
			endcase
			ev.event_code  = cur_q.rec.code0;
			ev.event_value = cur_q.rec.val0;
		end
		if (sel[1]) begin
			ev.event_type  = (cur_q.rec.kind == hidev_pkg::KindRel) ?
				hidev_pkg::EvRel : hidev_pkg::EvAbs;
			ev.event_code  = hidev_pkg::AxisY;
			ev.event_value = cur_q.rec.val1;
		end
		if (sel[2] || sel[8]) begin
			ev.event_type  = hidev_pkg::EvRel;
			ev.event_code  = hidev_pkg::RelWheel;
			ev.event_value = cur_q.rec.wheel;
		end
		for (int b = 0; b < hidev_pkg::NumButtons; b++) begin
			if (sel[3+b]) begin
				ev.event_type  = hidev_pkg::EvKey;
				ev.event_code  = hidev_pkg::ButtonCodes[b];
				ev.event_value = {31'd0, cur_q.rec.btn[b]};
			end
		end
		if (sel[hidev_pkg::NumSlots]) begin
			ev.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			pend_q <= job_pop ? {1'b1, job.rec.mask} : pend_nxt;
			if (out_adv) begin
				out_vld_q <= busy;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job;
		end
		if (out_adv && busy) begin
			out_q <= ev;
		end
	end

	assign empty    = !out_vld_q;
	assign out_item = out_q;

endmodule

// ===== rtl/hid_input_to_evdev_events.sv =====
// Translates keyboard and pointer notifications into input events, each stamped with
// seconds and microseconds of the nanosecond time. An item leaves one event per cycle
// while pop keeps the output moving, up to nine, closing sync included; items that
// yield nothing go no further than the input. The time stamp comes from a four-stage
// reciprocal multiply pipeline, followed by a 4-entry queue that absorbs stalls on the
// pop side; the first event of an item passes the pipeline, the queue, the job register
// and the output register before it reaches the result ports.
module hid_input_to_evdev_events (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_data,
	input  logic                  push,
	output logic                  full,
	input  hidev_pkg::hidev_in_t  in_item,
	output logic                  empty,
	input  logic                  pop,
	output hidev_pkg::hidev_out_t out_item
);

	hidev_pkg::hidev_rec_t rec;
	logic                  has_ev;
	logic                  accept;
	logic                  adv;
	logic                  st_vld;
	hidev_pkg::hidev_job_t st_job;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_pop;
	hidev_pkg::hidev_job_t q_job;

	assign adv    = !(st_vld && q_full);
	assign full   = !adv;
	assign accept = push && adv;

	hidev_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.accept   (accept),
		.in_item  (in_item),
		.rec      (rec),
		.has_ev   (has_ev)
	);

	hidev_stamp u_stamp (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (accept && has_ev),
		.in_rec  (rec),
		.time_ns (in_item.time_ns),
		.out_vld (st_vld),
		.out_job (st_job)
	);

	hidev_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (st_vld && !q_full),
		.wr_data    (st_job),
		.fifo_full  (q_full),
		.rd         (q_pop),
		.rd_data    (q_job),
		.fifo_empty (q_empty)
	);

	hidev_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (q_empty),
		.job       (q_job),
		.job_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule
